// ===== rtl/dbd_pkg.sv =====
// Package for the detection box decoder: widths, config codes and shared types.
// No dependencies; used by the interfaces, dbd_argmax and detection_box_decode_argmax.
package dbd_pkg;

    localparam int SCORE_W     = 16;
    localparam int COORD_W     = 16;
    localparam int CLASS_W     = 7;
    localparam int TOTAL_W     = 8;
    localparam int EDGE_LT_W   = 19;
    localparam int EDGE_RB_W   = 18;
    localparam int CFG_DATA_W  = 16;
    localparam int MAX_CLASSES = 128;

    localparam logic [SCORE_W-1:0] THRESH_RESET = SCORE_W'(32768);
    localparam logic [TOTAL_W-1:0] TOTAL_RESET  = TOTAL_W'(80);
    localparam logic [TOTAL_W-1:0] TOTAL_CLAMP  =
        TOTAL_W'((MAX_CLASSES < 128) ? MAX_CLASSES : 128);

    typedef enum logic {
        CFG_SCORE_THRESHOLD = 1'b0,
        CFG_CLASS_TOTAL     = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } t_geom;

    typedef struct packed {
        logic               last;
        logic               emit;
        logic [CLASS_W-1:0] class_id;
        logic [SCORE_W-1:0] best;
        t_geom              geom;
    } t_box_end;

    // zero means one class; anything above the class limit is clamped
    function automatic logic [TOTAL_W-1:0] eff_total(input logic [TOTAL_W-1:0] raw);
        logic [TOTAL_W-1:0] t;
        t = raw;
        if (t == '0) begin
            t = TOTAL_W'(1);
        end else if (t > TOTAL_CLAMP) begin
            t = TOTAL_CLAMP;
        end
        return t;
    endfunction

endpackage

// ===== rtl/dbd_req_if.sv =====
// Request channel of the detection box decoder: one class score plus box geometry.
// Depends on dbd_pkg.
interface dbd_req_if;
    import dbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic [SCORE_W-1:0] class_score;

    modport source (output valid, center_x, center_y, box_width, box_height, class_score,
                    input ready);
    modport sink   (input valid, center_x, center_y, box_width, box_height, class_score,
                    output ready);
endinterface

// ===== rtl/dbd_rsp_if.sv =====
// Detection channel of the detection box decoder: class, score and doubled corners.
// Depends on dbd_pkg.
interface dbd_rsp_if;
    import dbd_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [CLASS_W-1:0]          class_id;
    logic [SCORE_W-1:0]          best_score_out;
    logic signed [EDGE_LT_W-1:0] left_edge;
    logic signed [EDGE_LT_W-1:0] top_edge;
    logic [EDGE_RB_W-1:0]        right_edge;
    logic [EDGE_RB_W-1:0]        bottom_edge;

    modport source (output valid, class_id, best_score_out, left_edge, top_edge,
                    right_edge, bottom_edge, input ready);
    modport sink   (input valid, class_id, best_score_out, left_edge, top_edge,
                    right_edge, bottom_edge, output ready);
endinterface

// ===== rtl/dbd_argmax.sv =====
// Running class argmax per box: best score, best class, class counter, latched geometry.
// Depends on dbd_pkg; instantiated by detection_box_decode_argmax.
module dbd_argmax (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [dbd_pkg::SCORE_W-1:0]  i_score,
    input  dbd_pkg::t_geom               i_geom,
    input  logic [dbd_pkg::TOTAL_W-1:0]  i_total,
    input  logic [dbd_pkg::SCORE_W-1:0]  i_thresh,
    output dbd_pkg::t_box_end            o_end
);
    import dbd_pkg::*;

    logic [SCORE_W-1:0] r_best, n_best;
    logic [CLASS_W-1:0] r_class, n_class;
    logic [CLASS_W-1:0] r_cnt;
    t_geom              r_geom, n_geom;
    logic [TOTAL_W-1:0] cnt_inc;

    always_comb begin
        n_geom  = (r_cnt == '0) ? i_geom : r_geom;
        n_best  = r_best;
        n_class = r_class;
        if (i_score > r_best) begin
            n_best  = i_score;
            n_class = r_cnt;
        end
        cnt_inc        = {1'b0, r_cnt} + TOTAL_W'(1);
        o_end.last     = (cnt_inc >= i_total);
        o_end.emit     = (n_best > i_thresh);
        o_end.class_id = n_class;
        o_end.best     = n_best;
        o_end.geom     = n_geom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best  <= '0;
            r_class <= '0;
            r_cnt   <= '0;
            r_geom  <= '0;
        end else if (i_accept) begin
            if (o_end.last) begin
                r_best  <= '0;
                r_class <= '0;
                r_cnt   <= '0;
                r_geom  <= '0;
            end else begin
                r_best  <= n_best;
                r_class <= n_class;
                r_cnt   <= cnt_inc[CLASS_W-1:0];
                r_geom  <= n_geom;
            end
        end
    end

endmodule

// ===== rtl/detection_box_decode_argmax.sv =====
// Top level of the detection box decoder with class argmax.
// Depends on dbd_pkg, dbd_req_if, dbd_rsp_if and dbd_argmax.
//
// Usage:
//   i_req carries one class score per request together with the box centre and
//   size; a box is class_total consecutive requests, geometry taken from the first.
//   o_rsp carries at most one detection per box: best class, best score and the
//   doubled corners (2*centre -/+ size), only when the best score is strictly
//   above score_threshold.
//   Config: i_cfg_we with i_cfg_idx / i_cfg_data; write only while idle.
//   Throughput: one request per cycle from the running compare, unless stalled.
//   Latency: the detection is valid in the cycle after the last class request
//   of its box is accepted.
//   Stall: the detection sits in the output register; i_req.ready stays high
//   while that register is empty or being drained in the same cycle.
//   Reset: running state clears, threshold returns to 32768 and class total
//   to 80; no detection is pending.
module detection_box_decode_argmax (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  dbd_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [dbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dbd_req_if.sink                        i_req,
    dbd_rsp_if.source                      o_rsp
);
    import dbd_pkg::*;

    logic [SCORE_W-1:0] r_thresh;
    logic [TOTAL_W-1:0] r_total;
    logic               accept;
    t_geom              req_geom;
    t_box_end           box_end;

    logic                        r_valid;
    logic [CLASS_W-1:0]          r_class_id;
    logic [SCORE_W-1:0]          r_best;
    logic signed [EDGE_LT_W-1:0] r_left, r_top;
    logic [EDGE_RB_W-1:0]        r_right, r_bottom;
    logic signed [EDGE_LT_W-1:0] n_left, n_top;
    logic [EDGE_RB_W-1:0]        n_right, n_bottom;

    // config registers; total is stored already clamped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_total  <= TOTAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCORE_THRESHOLD: r_thresh <= i_cfg_data[SCORE_W-1:0];
                CFG_CLASS_TOTAL:     r_total  <= eff_total(i_cfg_data[TOTAL_W-1:0]);
                default: ;
            endcase
        end
    end

    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign req_geom.cx = i_req.center_x;
    assign req_geom.cy = i_req.center_y;
    assign req_geom.w  = i_req.box_width;
    assign req_geom.h  = i_req.box_height;

    dbd_argmax u_argmax (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_score  (i_req.class_score),
        .i_geom   (req_geom),
        .i_total  (r_total),
        .i_thresh (r_thresh),
        .o_end    (box_end)
    );

    always_comb begin
        n_left   = $signed({2'b00, box_end.geom.cx, 1'b0}) - $signed({3'b000, box_end.geom.w});
        n_top    = $signed({2'b00, box_end.geom.cy, 1'b0}) - $signed({3'b000, box_end.geom.h});
        n_right  = {1'b0, box_end.geom.cx, 1'b0} + {2'b00, box_end.geom.w};
        n_bottom = {1'b0, box_end.geom.cy, 1'b0} + {2'b00, box_end.geom.h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept && box_end.last && box_end.emit) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && box_end.last && box_end.emit) begin
            r_class_id <= box_end.class_id;
            r_best     <= box_end.best;
            r_left     <= n_left;
            r_top      <= n_top;
            r_right    <= n_right;
            r_bottom   <= n_bottom;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.class_id       = r_class_id;
    assign o_rsp.best_score_out = r_best;
    assign o_rsp.left_edge      = r_left;
    assign o_rsp.top_edge       = r_top;
    assign o_rsp.right_edge     = r_right;
    assign o_rsp.bottom_edge    = r_bottom;

    a_stall_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready)
        else $error("request taken while detection is stalled");

    a_score_above_thresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.best_score_out > r_thresh))
        else $error("detection at or below threshold");

    a_rise_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(accept))
        else $error("detection without a request");

    a_new_det_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !box_end.last) |=> !(o_rsp.valid && !$past(o_rsp.valid && !o_rsp.ready)
            && !$past(o_rsp.valid)))
        else $error("detection from a request that did not end a box");

endmodule

// ===== dv/tb_detection_box_decode_argmax.sv =====
// Testbench for detection_box_decode_argmax: streams class-score requests, predicts the
// per-box argmax detection in-bench and checks every detection field by field.
// Depends on dbd_pkg, dbd_req_if, dbd_rsp_if and the RTL top level.
module tb_detection_box_decode_argmax;
    import dbd_pkg::*;

    localparam int HOLD_LEN      = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [SCORE_W-1:0] score;
    } t_score_req;

    typedef struct {
        logic [CLASS_W-1:0]          class_id;
        logic [SCORE_W-1:0]          best;
        logic signed [EDGE_LT_W-1:0] left_e;
        logic signed [EDGE_LT_W-1:0] top_e;
        logic [EDGE_RB_W-1:0]        right_e;
        logic [EDGE_RB_W-1:0]        bottom_e;
    } t_detection;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    t_cfg_idx              cfg_idx  = CFG_SCORE_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    dbd_req_if req_ch();
    dbd_rsp_if rsp_ch();

    detection_box_decode_argmax dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the block's registers and running box state
    logic [SCORE_W-1:0] thr_mirror   = THRESH_RESET;
    logic [TOTAL_W-1:0] total_mirror = TOTAL_RESET;
    logic [SCORE_W-1:0] best_so_far  = '0;
    logic [CLASS_W-1:0] best_class   = '0;
    logic [CLASS_W-1:0] slot_pos     = '0;
    t_geom              box_geom     = '0;

    t_score_req score_reqs[$];
    t_detection detections_due[$];

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   fail_count    = 0;
    int   quiet_cycles  = 0;
    int   hold_cnt      = 0;
    logic hold_arm      = 1'b0;

    task automatic absorb_request(input t_score_req r);
        int         eff;
        t_detection d;
        eff = (total_mirror == '0) ? 1 : int'(total_mirror);
        if (eff > MAX_CLASSES) eff = MAX_CLASSES;
        if (eff > 128) eff = 128;
        if (slot_pos == '0) box_geom = {r.cx, r.cy, r.w, r.h};
        if (r.score > best_so_far) begin
            best_so_far = r.score;
            best_class  = slot_pos;
        end
        if (int'(slot_pos) + 1 < eff) begin
            slot_pos = slot_pos + 1'b1;
            return;
        end
        if (best_so_far > thr_mirror) begin
            d.class_id = best_class;
            d.best     = best_so_far;
            d.left_e   = EDGE_LT_W'(2 * int'(box_geom.cx) - int'(box_geom.w));
            d.top_e    = EDGE_LT_W'(2 * int'(box_geom.cy) - int'(box_geom.h));
            d.right_e  = EDGE_RB_W'(2 * int'(box_geom.cx) + int'(box_geom.w));
            d.bottom_e = EDGE_RB_W'(2 * int'(box_geom.cy) + int'(box_geom.h));
            detections_due.insert(detections_due.size(), d);
        end
        best_so_far = '0;
        best_class  = '0;
        slot_pos    = '0;
        box_geom    = '0;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : req_driver
        t_score_req got;
        t_score_req nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                got.cx    = req_ch.center_x;
                got.cy    = req_ch.center_y;
                got.w     = req_ch.box_width;
                got.h     = req_ch.box_height;
                got.score = req_ch.class_score;
                absorb_request(got);
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (score_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = score_reqs.pop_front();
                    req_ch.center_x    <= nxt.cx;
                    req_ch.center_y    <= nxt.cy;
                    req_ch.box_width   <= nxt.w;
                    req_ch.box_height  <= nxt.h;
                    req_ch.class_score <= nxt.score;
                    req_ch.valid       <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // detection monitor and receiver backpressure
    always @(posedge i_clk) begin : det_monitor
        t_detection exp_d;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (detections_due.size() == 0) begin
                    $error("unexpected detection: class_id %0d score %0d",
                           rsp_ch.class_id, rsp_ch.best_score_out);
                    fail_count++;
                end else begin
                    exp_d = detections_due.pop_front();
                    check_field("class_id", exp_d.class_id, rsp_ch.class_id);
                    check_field("best_score_out", exp_d.best, rsp_ch.best_score_out);
                    check_field("left_edge", exp_d.left_e, rsp_ch.left_edge);
                    check_field("top_edge", exp_d.top_e, rsp_ch.top_edge);
                    check_field("right_edge", exp_d.right_e, rsp_ch.right_edge);
                    check_field("bottom_edge", exp_d.bottom_e, rsp_ch.bottom_edge);
                end
            end
            if (hold_arm && hold_cnt < HOLD_LEN) begin
                hold_cnt     <= hold_cnt + 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic push_req(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                            input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
                            input logic [SCORE_W-1:0] score);
        t_score_req r;
        r.cx    = cx;
        r.cy    = cy;
        r.w     = w;
        r.h     = h;
        r.score = score;
        score_reqs.insert(score_reqs.size(), r);
    endtask

    task automatic push_random(input int count);
        logic [SCORE_W-1:0] s;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                0:       s = '0;
                1:       s = '1;
                2, 3:    s = thr_mirror + SCORE_W'($urandom_range(4)) - SCORE_W'(2);
                default: s = SCORE_W'($urandom);
            endcase
            push_req(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), s);
        end
    endtask

    task automatic program_regs(input logic [SCORE_W-1:0] thr,
                                input logic [CFG_DATA_W-1:0] total_word);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SCORE_THRESHOLD;
        cfg_data <= thr;
        @(posedge i_clk);
        cfg_idx  <= CFG_CLASS_TOTAL;
        cfg_data <= total_word;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        thr_mirror   = thr;
        total_mirror = total_word[TOTAL_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic set_pace(input int idle, input int stall);
        send_idle_pct <= idle;
        stall_pct     <= stall;
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (score_reqs.size() != 0 || req_ch.valid || detections_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [SCORE_W-1:0] thr;
        logic [TOTAL_W-1:0] tot;
        int                 peak;

        req_ch.valid       = 1'b0;
        req_ch.center_x    = '0;
        req_ch.center_y    = '0;
        req_ch.box_width   = '0;
        req_ch.box_height  = '0;
        req_ch.class_score = '0;
        rsp_ch.ready       = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default registers: one 80-class box, a single score above threshold
        peak = $urandom_range(79);
        for (int n = 0; n < 80; n++) begin
            push_req(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom),
                     (n == peak) ? SCORE_W'($urandom_range(16'hFFFF, 16'h8001))
                                 : SCORE_W'($urandom_range(16'h8000)));
        end
        drain();

        // single class per box, coordinate and score extremes
        program_regs('0, 16'd1);
        push_req('0, '0, '0, '0, '0);
        push_req('1, '1, '1, '1, '1);
        push_req('0, '0, '1, '1, 16'd1);
        push_req('1, '0, '0, '1, 16'h8000);
        drain();

        // zero class total acts as one; max threshold blocks everything
        program_regs('1, 16'h0000);
        push_req(16'd1, 16'd2, 16'd3, 16'd4, '1);
        drain();
        program_regs(16'h8000, 16'hA500);
        push_req(16'h1234, 16'h5678, 16'h0100, 16'h0200, 16'h8000);
        push_req(16'h1234, 16'h5678, 16'h0100, 16'h0200, 16'h8001);
        drain();

        // three classes: ties keep the first, geometry from the first request only
        program_regs(16'd100, 16'd3);
        push_req(16'd500, 16'd600, 16'd40, 16'd60, 16'd200);
        push_req(16'd1, 16'd1, 16'd1, 16'd1, 16'd200);
        push_req(16'd2, 16'd2, 16'd2, 16'd2, 16'd100);
        push_req(16'd10, 16'd20, 16'd30, 16'd40, 16'd50);
        push_req(16'd9, 16'd9, 16'd9, 16'd9, 16'd99);
        push_req(16'd8, 16'd8, 16'd8, 16'd8, 16'd101);
        push_req(16'd7, 16'd7, 16'd7, 16'd7, 16'd100);
        push_req(16'd6, 16'd6, 16'd6, 16'd6, 16'd100);
        push_req(16'd5, 16'd5, 16'd5, 16'd5, 16'd100);
        drain();

        // class total lowered in the middle of a box
        program_regs('0, 16'd5);
        push_req(16'd300, 16'd400, 16'd500, 16'd600, 16'd7);
        push_req(16'd1, 16'd1, 16'd1, 16'd1, 16'd9);
        push_req(16'd1, 16'd1, 16'd1, 16'd1, 16'd3);
        drain();
        program_regs('0, 16'd2);
        push_req(16'd2, 16'd2, 16'd2, 16'd2, 16'd1);
        push_req(16'd70, 16'd80, 16'd90, 16'd100, '0);
        push_req(16'd3, 16'd3, 16'd3, 16'd3, 16'd5);
        drain();

        // oversized class total clamps to the class limit
        program_regs(16'd1, 16'h00FF);
        push_random(128);
        drain();

        // long receiver hold while requests keep coming
        program_regs('0, 16'd1);
        hold_arm <= 1'b1;
        for (int n = 0; n < 40; n++) begin
            push_req(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     COORD_W'($urandom), SCORE_W'($urandom_range(16'hFFFF, 1)));
        end
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(7))
                0:       thr = '0;
                1:       thr = '1;
                2, 3:    thr = SCORE_W'($urandom_range(16'h4000));
                default: thr = SCORE_W'($urandom);
            endcase
            case ($urandom_range(9))
                0:       tot = '0;
                1:       tot = 8'd1;
                2:       tot = TOTAL_W'($urandom_range(20, 9));
                default: tot = TOTAL_W'($urandom_range(6, 2));
            endcase
            program_regs(thr, {8'($urandom), tot});
            case (ph % 4)
                0:       set_pace(0, 0);
                1:       set_pace(88, 0);
                2:       set_pace(0, 88);
                default: set_pace(6, 6);
            endcase
            push_random(30);
            drain();
        end

        if (fail_count == 0 && detections_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
